// ===== rtl/core/masked_grid_triangulator_core_macros.svh =====
`ifndef MASKED_GRID_TRIANGULATOR_CORE_MACROS_SVH
`define MASKED_GRID_TRIANGULATOR_CORE_MACROS_SVH

// same-cycle implication
`define MGT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mgt check failed");

// next-cycle implication
`define MGT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mgt check failed");

`endif

// ===== rtl/core/mgt_pkg.sv =====
package mgt_pkg;

  localparam int CFG_W    = 11;
  localparam int ID_W     = 21;
  localparam int CORNER_W = 20;
  localparam int POS_W    = 10;
  localparam int ELEV_W   = 32;
  localparam int CNT_W    = 21;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 3;

  localparam logic [CNT_W-1:0] CNT_MAX    = '1;
  localparam logic [CFG_W-1:0] GRID_RESET = 11'd1024;

  // register index, taken from paddr[2]
  localparam logic REG_GRID_WIDTH  = 1'b0;
  localparam logic REG_GRID_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_TOTALS   = 2'd2
  } rec_kind_t;

  typedef struct packed {
    logic              cell_valid;
    logic [ELEV_W-1:0] elevation_bits;
  } cell_t;

  typedef struct packed {
    rec_kind_t           kind;
    logic [CORNER_W-1:0] corner_a;
    logic [CORNER_W-1:0] corner_b;
    logic [CORNER_W-1:0] corner_c;
    logic [POS_W-1:0]    cell_col;
    logic [POS_W-1:0]    cell_row;
    logic [ELEV_W-1:0]   vertex_elevation;
    logic [CNT_W-1:0]    vertex_total;
    logic [CNT_W-1:0]    triangle_total;
    logic                mesh_empty;
    logic                last;
  } rec_t;

endpackage

// ===== rtl/core/mgt_ram.sv =====
module mgt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/masked_grid_triangulator_core.sv =====
// channel  direction  handshake                      payload
// cfg      in         psel, penable, pwrite, pready  paddr, pwdata; prdata back
// cell     in         cell_req_valid, cell_req_stall mgt_pkg::cell_t
// rec      out        rec_valid, rec_stall           mgt_pkg::rec_t
//
// a cell request can be taken every cycle while cell_req_stall is low
// one cell yields 0 to 4 records and holds the single record port until all are sent
// the previous-row id memory is read at accept and written back in the next cycle
// rst clears position, counters and queues; the id memory is not cleared
// cell_req_stall is high while queued entries plus the cell in compute reach three
module masked_grid_triangulator_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mgt_pkg::PADDR_W-1:0]  paddr,
  input  logic [mgt_pkg::DATA_W-1:0]   pwdata,
  output logic [mgt_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         cell_req_valid,
  output logic                         cell_req_stall,
  input  mgt_pkg::cell_t               cell_req,
  output logic                         rec_valid,
  input  logic                         rec_stall,
  output mgt_pkg::rec_t                rec
);

  import mgt_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WCW = (CFG_W > $clog2(MAX_WIDTH + 1)) ? CFG_W + 1 : $clog2(MAX_WIDTH + 1) + 1;
  localparam int HCW = (CFG_W > $clog2(MAX_HEIGHT + 1)) ? CFG_W + 1 : $clog2(MAX_HEIGHT + 1) + 1;
  localparam int MW  = ID_W + 1;
  localparam int BQ_DEPTH = 3;
  localparam int BQ_PW    = $clog2(BQ_DEPTH);
  localparam int BQ_CW    = $clog2(BQ_DEPTH + 1);

  typedef struct packed {
    logic [3:0]        mask;
    logic [ID_W-1:0]   cur;
    logic [ID_W-1:0]   up;
    logic [ID_W-1:0]   ul;
    logic [ID_W-1:0]   left;
    logic [POS_W-1:0]  col;
    logic [POS_W-1:0]  row;
    logic [ELEV_W-1:0] elev;
    logic [CNT_W-1:0]  vt;
    logic [CNT_W-1:0]  tt;
    logic              empty;
  } bnd_t;

  // configuration
  logic             cfg_wr;
  logic             cfg_sel;
  logic [CFG_W-1:0] grid_width;
  logic [CFG_W-1:0] grid_height;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_sel = paddr[PADDR_W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_RESET;
      grid_height <= GRID_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_GRID_WIDTH:  grid_width  <= pwdata[CFG_W-1:0];
        REG_GRID_HEIGHT: grid_height <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_GRID_WIDTH:  prdata = DATA_W'(grid_width);
      REG_GRID_HEIGHT: prdata = DATA_W'(grid_height);
      default:         prdata = '0;
    endcase
  end

  // effective geometry
  logic [WCW-1:0] w_eff;
  logic [HCW-1:0] h_eff;

  always_comb begin
    if (grid_width < CFG_W'(2)) begin
      w_eff = WCW'(2);
    end else if (WCW'(grid_width) > WCW'(MAX_WIDTH)) begin
      w_eff = WCW'(MAX_WIDTH);
    end else begin
      w_eff = WCW'(grid_width);
    end
    if (grid_height < CFG_W'(2)) begin
      h_eff = HCW'(2);
    end else if (HCW'(grid_height) > HCW'(MAX_HEIGHT)) begin
      h_eff = HCW'(MAX_HEIGHT);
    end else begin
      h_eff = HCW'(grid_height);
    end
  end

  // raster position
  logic          accept;
  logic [AW-1:0] col_count;
  logic [RW-1:0] row_count;
  logic          col_end;
  logic          row_end;

  assign accept  = cell_req_valid & ~cell_req_stall;
  assign col_end = (WCW'(col_count) + WCW'(1)) >= w_eff;
  assign row_end = (HCW'(row_count) + HCW'(1)) >= h_eff;

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_count <= '0;
        row_count <= row_end ? '0 : row_count + RW'(1);
      end else begin
        col_count <= col_count + AW'(1);
      end
    end
  end

  // compute stage
  logic          s1_vld;
  cell_t         s1_cell;
  logic [AW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  logic          s1_col_end;
  logic          s1_frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cell      <= cell_req;
      s1_col       <= col_count;
      s1_row       <= row_count;
      s1_col_end   <= col_end;
      s1_frame_end <= col_end & row_end;
    end
  end

  logic [MW-1:0] up_rd;
  logic [MW-1:0] up_wr;

  mgt_ram #(
    .WIDTH (MW),
    .DEPTH (MAX_WIDTH)
  ) u_upper_row (
    .clk   (clk),
    .we    (s1_vld),
    .waddr (s1_col),
    .wdata (up_wr),
    .re    (accept),
    .raddr (col_count),
    .rdata (up_rd)
  );

  logic [ID_W-1:0]  left_id;
  logic             left_ok;
  logic [ID_W-1:0]  ul_id;
  logic             ul_ok;
  logic [CNT_W-1:0] vtx_cnt;
  logic [CNT_W-1:0] tri_cnt;

  logic             cv;
  logic             up_ok;
  logic [ID_W-1:0]  up_id;
  logic             win;
  logic             t1;
  logic             t2;
  logic [CNT_W-1:0] vtx_new;
  logic [CNT_W:0]   tri_sum;
  logic [CNT_W-1:0] tri_new;
  logic [3:0]       mask;
  logic             push;
  bnd_t             bnd_in;

  assign cv      = s1_cell.cell_valid;
  assign up_ok   = (s1_row != '0) & up_rd[MW-1];
  assign up_id   = (s1_row != '0) ? up_rd[ID_W-1:0] : '0;
  assign win     = (s1_row != '0) & (s1_col != '0);
  assign t1      = win & ul_ok & up_ok & cv;
  assign t2      = win & ul_ok & cv & left_ok;
  assign vtx_new = (cv && vtx_cnt != CNT_MAX) ? vtx_cnt + CNT_W'(1) : vtx_cnt;
  assign tri_sum = (CNT_W + 1)'(tri_cnt) + (CNT_W + 1)'(t1) + (CNT_W + 1)'(t2);
  assign tri_new = (tri_sum > (CNT_W + 1)'(CNT_MAX)) ? CNT_MAX : tri_sum[CNT_W-1:0];
  assign mask    = {s1_frame_end, t2, t1, cv};
  assign push    = s1_vld & (mask != '0);
  assign up_wr   = {cv, cv ? vtx_cnt : ID_W'(0)};

  always_comb begin
    bnd_in       = '0;
    bnd_in.mask  = mask;
    bnd_in.cur   = vtx_cnt;
    bnd_in.up    = up_id;
    bnd_in.ul    = ul_id;
    bnd_in.left  = left_id;
    bnd_in.col   = POS_W'(s1_col);
    bnd_in.row   = POS_W'(s1_row);
    bnd_in.elev  = s1_cell.elevation_bits;
    bnd_in.vt    = vtx_new;
    bnd_in.tt    = tri_new;
    bnd_in.empty = (vtx_new == '0) | (tri_new == '0);
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      left_id <= '0;
      left_ok <= 1'b0;
      ul_id   <= '0;
      ul_ok   <= 1'b0;
      vtx_cnt <= '0;
      tri_cnt <= '0;
    end else if (s1_vld) begin
      if (s1_col_end) begin
        left_id <= '0;
        left_ok <= 1'b0;
        ul_id   <= '0;
        ul_ok   <= 1'b0;
      end else begin
        left_id <= cv ? vtx_cnt : '0;
        left_ok <= cv;
        ul_id   <= up_id;
        ul_ok   <= up_ok;
      end
      if (s1_frame_end) begin
        vtx_cnt <= '0;
        tri_cnt <= '0;
      end else begin
        vtx_cnt <= vtx_new;
        tri_cnt <= tri_new;
      end
    end
  end

  // record queue
  bnd_t             bq [BQ_DEPTH];
  logic [BQ_PW-1:0] bq_wp;
  logic [BQ_PW-1:0] bq_rp;
  logic [BQ_CW-1:0] bq_cnt;
  logic             pop;

  assign cell_req_stall = ((BQ_CW + 1)'(bq_cnt) + (BQ_CW + 1)'(s1_vld))
                          > (BQ_CW + 1)'(BQ_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (push) begin
      bq[bq_wp] <= bnd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bq_wp  <= '0;
      bq_rp  <= '0;
      bq_cnt <= '0;
    end else begin
      if (push) begin
        bq_wp <= (bq_wp == BQ_PW'(BQ_DEPTH - 1)) ? '0 : bq_wp + BQ_PW'(1);
      end
      if (pop) begin
        bq_rp <= (bq_rp == BQ_PW'(BQ_DEPTH - 1)) ? '0 : bq_rp + BQ_PW'(1);
      end
      bq_cnt <= bq_cnt + BQ_CW'(push) - BQ_CW'(pop);
    end
  end

  // serializer
  bnd_t       head;
  logic       head_vld;
  logic [3:0] sent;
  logic [3:0] rem;
  logic [3:0] pick;
  logic       is_last;
  logic       load;
  rec_t       rec_next;

  assign head     = bq[bq_rp];
  assign head_vld = bq_cnt != '0;
  assign rem      = head.mask & ~sent;
  assign pick     = rem & (~rem + 4'd1);
  assign is_last  = (rem & ~pick) == '0;
  assign load     = head_vld & (~rec_valid | ~rec_stall);
  assign pop      = load & is_last;

  always_comb begin
    rec_next      = '0;
    rec_next.last = is_last;
    if (pick[0]) begin
      rec_next.kind             = KIND_VERTEX;
      rec_next.corner_a         = CORNER_W'(head.cur);
      rec_next.cell_col         = head.col;
      rec_next.cell_row         = head.row;
      rec_next.vertex_elevation = head.elev;
    end else if (pick[1]) begin
      rec_next.kind     = KIND_TRIANGLE;
      rec_next.corner_a = CORNER_W'(head.ul);
      rec_next.corner_b = CORNER_W'(head.up);
      rec_next.corner_c = CORNER_W'(head.cur);
    end else if (pick[2]) begin
      rec_next.kind     = KIND_TRIANGLE;
      rec_next.corner_a = CORNER_W'(head.ul);
      rec_next.corner_b = CORNER_W'(head.cur);
      rec_next.corner_c = CORNER_W'(head.left);
    end else begin
      rec_next.kind           = KIND_TOTALS;
      rec_next.vertex_total   = head.vt;
      rec_next.triangle_total = head.tt;
      rec_next.mesh_empty     = head.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
      sent      <= '0;
    end else if (load) begin
      rec_valid <= 1'b1;
      sent      <= is_last ? '0 : (sent | pick);
    end else if (!rec_stall) begin
      rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rec <= rec_next;
    end
  end

endmodule

// ===== rtl/core/mgt_chk.sv =====
`include "masked_grid_triangulator_core_macros.svh"

module mgt_chk (
  input logic          clk,
  input logic          rst,
  input logic          rec_valid,
  input logic          rec_stall,
  input mgt_pkg::rec_t rec
);

  import mgt_pkg::*;

  logic rec_take;

  assign rec_take = rec_valid & ~rec_stall;

  `MGT_ASSERT_NEXT(a_rec_hold, rec_valid && rec_stall, rec_valid && $stable(rec))
  `MGT_ASSERT_NEXT(a_burst_cont, rec_take && !rec.last, rec_valid)
  `MGT_ASSERT_NEXT(a_one_vertex, rec_take && !rec.last && rec.kind == KIND_VERTEX, rec.kind != KIND_VERTEX)
  `MGT_ASSERT_NOW(a_totals_last, rec_valid && rec.kind == KIND_TOTALS, rec.last)

endmodule

bind masked_grid_triangulator_core mgt_chk u_mgt_chk (.*);

// ===== bench/mgt_record_checker.sv =====
`timescale 1ns / 100ps

module mgt_record_checker
  import mgt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]  pwdata,
  input  logic [DATA_W-1:0]  prdata,
  input  logic               pready,
  input  logic               cell_req_valid,
  input  logic               cell_req_stall,
  input  cell_t              cell_req,
  input  logic               rec_valid,
  input  logic               rec_stall,
  input  rec_t               rec,
  output int                 fail_count,
  output int                 pending,
  output int                 rec_count,
  output int                 frame_count
);

  localparam int GRID_MAX = 1024;

  logic [CFG_W-1:0] grid_w;
  logic [CFG_W-1:0] grid_h;
  logic [ID_W-1:0]  above_id [GRID_MAX];
  bit               above_ok [GRID_MAX];
  logic [ID_W-1:0]  left_id;
  logic [ID_W-1:0]  diag_id;
  bit               left_ok;
  bit               diag_ok;
  int unsigned      col_pos;
  int unsigned      row_pos;
  logic [CNT_W-1:0] vert_cnt;
  logic [CNT_W-1:0] tri_cnt;
  rec_t             expected_recs[$];
  int               fails = 0;
  int               seen = 0;
  int               frames = 0;
  int               queued = 0;

  assign fail_count  = fails;
  assign pending     = queued;
  assign rec_count   = seen;
  assign frame_count = frames;

  function automatic int unsigned span(logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > GRID_MAX) return GRID_MAX;
    return int'(v);
  endfunction

  task automatic restart_frame();
    left_id  = '0;
    left_ok  = 1'b0;
    diag_id  = '0;
    diag_ok  = 1'b0;
    col_pos  = 0;
    row_pos  = 0;
    vert_cnt = '0;
    tri_cnt  = '0;
  endtask

  function automatic rec_t triangle(logic [ID_W-1:0] a, logic [ID_W-1:0] b,
                                    logic [ID_W-1:0] c);
    rec_t r;
    r          = '0;
    r.kind     = KIND_TRIANGLE;
    r.corner_a = a[CORNER_W-1:0];
    r.corner_b = b[CORNER_W-1:0];
    r.corner_c = c[CORNER_W-1:0];
    return r;
  endfunction

  task automatic predict_cell(cell_t c);
    int unsigned     w;
    int unsigned     h;
    int unsigned     col;
    int unsigned     row;
    logic [ID_W-1:0] cur;
    logic [ID_W-1:0] up;
    bit              up_ok;
    bit              valid;
    rec_t            r;
    rec_t            batch[$];
    int              n;
    w     = span(grid_w);
    h     = span(grid_h);
    valid = c.cell_valid;
    col   = (col_pos >= w) ? w - 1 : col_pos;
    row   = (row_pos >= h) ? h - 1 : row_pos;
    cur   = '0;
    up    = '0;
    up_ok = 1'b0;

    if (valid) begin
      cur                = vert_cnt;
      r                  = '0;
      r.kind             = KIND_VERTEX;
      r.corner_a         = cur[CORNER_W-1:0];
      r.cell_col         = col[POS_W-1:0];
      r.cell_row         = row[POS_W-1:0];
      r.vertex_elevation = c.elevation_bits;
      batch              = {batch, r};
      if (vert_cnt != CNT_MAX) vert_cnt++;
    end

    if (row > 0) begin
      up    = above_id[col];
      up_ok = above_ok[col];
    end

    if (row > 0 && col > 0) begin
      if (diag_ok && up_ok && valid) begin
        batch = {batch, triangle(diag_id, up, cur)};
        if (tri_cnt != CNT_MAX) tri_cnt++;
      end
      if (diag_ok && valid && left_ok) begin
        batch = {batch, triangle(diag_id, cur, left_id)};
        if (tri_cnt != CNT_MAX) tri_cnt++;
      end
    end

    diag_id       = up;
    diag_ok       = up_ok;
    above_id[col] = cur;
    above_ok[col] = valid;
    left_id       = cur;
    left_ok       = valid;

    if (col + 1 >= w) begin
      col_pos = 0;
      left_id = '0;
      left_ok = 1'b0;
      diag_id = '0;
      diag_ok = 1'b0;
      if (row + 1 >= h) begin
        r                = '0;
        r.kind           = KIND_TOTALS;
        r.vertex_total   = vert_cnt;
        r.triangle_total = tri_cnt;
        r.mesh_empty     = (vert_cnt == 0) || (tri_cnt == 0);
        batch            = {batch, r};
        frames++;
        restart_frame();
      end else begin
        row_pos = row + 1;
      end
    end else begin
      col_pos = col + 1;
      row_pos = row;
    end

    n = batch.size();
    if (n > 0) batch[n-1].last = 1'b1;
    expected_recs = {expected_recs, batch};
  endtask

  function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                      logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  task automatic compare_rec(rec_t got);
    rec_t want;
    seen++;
    if (expected_recs.size() == 0) begin
      $error("record with nothing expected: kind %0h", got.kind);
      fails++;
    end else begin
      want = expected_recs.pop_front();
      check_field("kind", DATA_W'(want.kind), DATA_W'(got.kind));
      check_field("corner_a", DATA_W'(want.corner_a), DATA_W'(got.corner_a));
      check_field("corner_b", DATA_W'(want.corner_b), DATA_W'(got.corner_b));
      check_field("corner_c", DATA_W'(want.corner_c), DATA_W'(got.corner_c));
      check_field("cell_col", DATA_W'(want.cell_col), DATA_W'(got.cell_col));
      check_field("cell_row", DATA_W'(want.cell_row), DATA_W'(got.cell_row));
      check_field("vertex_elevation", want.vertex_elevation, got.vertex_elevation);
      check_field("vertex_total", DATA_W'(want.vertex_total), DATA_W'(got.vertex_total));
      check_field("triangle_total", DATA_W'(want.triangle_total),
                  DATA_W'(got.triangle_total));
      check_field("mesh_empty", DATA_W'(want.mesh_empty), DATA_W'(got.mesh_empty));
      check_field("last", DATA_W'(want.last), DATA_W'(got.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      grid_w = GRID_RESET;
      grid_h = GRID_RESET;
      foreach (above_id[i]) begin
        above_id[i] = '0;
        above_ok[i] = 1'b0;
      end
      restart_frame();
      expected_recs.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_GRID_WIDTH) grid_w = pwdata[CFG_W-1:0];
          else grid_h = pwdata[CFG_W-1:0];
          restart_frame();
        end else if (paddr[2] == REG_GRID_WIDTH) begin
          check_field("prdata grid_width", DATA_W'(grid_w), prdata);
        end else begin
          check_field("prdata grid_height", DATA_W'(grid_h), prdata);
        end
      end
      if (cell_req_valid && !cell_req_stall) predict_cell(cell_req);
      if (rec_valid && !rec_stall) compare_rec(rec);
    end
    queued = expected_recs.size();
  end

endmodule

// ===== bench/masked_grid_triangulator_core_tb.sv =====
`timescale 1ns / 100ps

module masked_grid_triangulator_core_tb;
  import mgt_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0]  pwdata = '0;
  logic [DATA_W-1:0]  prdata;
  logic               pready;
  logic               cell_req_valid = 1'b0;
  logic               cell_req_stall;
  cell_t              cell_req = '0;
  logic               rec_valid;
  logic               rec_stall = 1'b0;
  rec_t               rec;

  int fail_count;
  int pending;
  int rec_count;
  int frame_count;

  bit               steady = 1'b0;
  int               cells_sent = 0;
  int               settings = 0;
  int               random_cells = 0;
  logic [CFG_W-1:0] cur_w = GRID_RESET;
  logic [CFG_W-1:0] cur_h = GRID_RESET;

  masked_grid_triangulator_core u_dut (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .cell_req_valid (cell_req_valid),
    .cell_req_stall (cell_req_stall),
    .cell_req       (cell_req),
    .rec_valid      (rec_valid),
    .rec_stall      (rec_stall),
    .rec            (rec)
  );

  mgt_record_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .cell_req_valid (cell_req_valid),
    .cell_req_stall (cell_req_stall),
    .cell_req       (cell_req),
    .rec_valid      (rec_valid),
    .rec_stall      (rec_stall),
    .rec            (rec),
    .fail_count     (fail_count),
    .pending        (pending),
    .rec_count      (rec_count),
    .frame_count    (frame_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    rec_stall <= !steady && ($urandom_range(99) < 13);
  end

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int span(logic [CFG_W-1:0] v);
    if (v < 2) return 2;
    if (v > 1024) return 1024;
    return int'(v);
  endfunction

  task automatic apb_access(input bit wr, input logic idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // cell requests, with random gaps
  task automatic send_cell(input bit valid, input logic [ELEV_W-1:0] elev);
    cell_t c;
    bit    taken;
    while (!steady && $urandom_range(99) < 13) begin
      cell_req_valid <= 1'b0;
      @(posedge clk);
    end
    c.cell_valid     = valid;
    c.elevation_bits = elev;
    cell_req_valid <= 1'b1;
    cell_req       <= c;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !cell_req_stall;
      @(posedge clk);
    end
    cells_sent++;
  endtask

  task automatic drain();
    cell_req_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input bit set_w, input bit set_h);
    drain();
    repeat (8) @(posedge clk);
    if (set_w) begin
      apb_access(1'b1, REG_GRID_WIDTH, w);
      cur_w = w;
    end
    if (set_h) begin
      apb_access(1'b1, REG_GRID_HEIGHT, h);
      cur_h = h;
    end
    apb_access(1'b0, REG_GRID_WIDTH, '0);
    apb_access(1'b0, REG_GRID_HEIGHT, '0);
    settings++;
  endtask

  task automatic send_cells(input int count, input int pct);
    logic [ELEV_W-1:0] elev;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(7))
        0:       elev = '0;
        1:       elev = '1;
        default: elev = $urandom;
      endcase
      send_cell($urandom_range(99) < pct, elev);
    end
  endtask

  initial begin
    int area;
    int count;
    int pct;
    int mode;
    int phase;
    logic [CFG_W-1:0] w_raw;
    logic [CFG_W-1:0] h_raw;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset geometry
    apb_access(1'b0, REG_GRID_WIDTH, '0);
    apb_access(1'b0, REG_GRID_HEIGHT, '0);
    send_cell(1'b1, 32'h0000_0000);
    send_cell(1'b0, 32'hFFFF_FFFF);
    send_cell(1'b1, 32'hFFFF_FFFF);

    // smallest frame: both triangles, each one alone, no vertices, no triangles
    configure(11'd2, 11'd2, 1'b1, 1'b1);
    send_cell(1'b1, 32'h0000_0000);
    send_cell(1'b1, 32'hFFFF_FFFF);
    send_cell(1'b1, 32'hAAAA_AAAA);
    send_cell(1'b1, 32'h5555_5555);
    send_cell(1'b1, 32'h1234_5678);
    send_cell(1'b1, 32'h8000_0001);
    send_cell(1'b0, 32'hFFFF_FFFF);
    send_cell(1'b1, 32'h7FFF_FFFE);
    send_cell(1'b1, 32'hDEAD_BEEF);
    send_cell(1'b0, 32'h0000_0000);
    send_cell(1'b1, 32'h0F0F_0F0F);
    send_cell(1'b1, 32'hF0F0_F0F0);
    send_cell(1'b0, 32'hFFFF_FFFF);
    send_cell(1'b0, 32'h0000_0000);
    send_cell(1'b0, 32'hA5A5_A5A5);
    send_cell(1'b0, 32'h5A5A_5A5A);
    send_cell(1'b1, 32'hCAFE_F00D);
    send_cell(1'b0, 32'h0000_0001);
    send_cell(1'b0, 32'h8000_0000);
    send_cell(1'b1, 32'hFFFF_FFFF);

    // geometry below the range acts as 2
    configure(11'd0, 11'd1, 1'b1, 1'b1);
    send_cells(4, 100);

    // geometry above the range, start of a wide and of a tall frame
    configure(11'd2047, 11'd2, 1'b1, 1'b1);
    steady = 1'b1;
    send_cells(24, 90);
    steady = 1'b0;
    configure(11'd1, 11'd2047, 1'b1, 1'b1);
    send_cells(24, 90);

    phase = 0;
    while (random_cells < 320) begin
      w_raw = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(1)) : CFG_W'($urandom_range(2, 9));
      h_raw = ($urandom_range(9) == 0) ? CFG_W'($urandom_range(1)) : CFG_W'($urandom_range(2, 6));
      mode = $urandom_range(3);
      configure(w_raw, h_raw, mode != 1, mode != 0);
      area  = span(cur_w) * span(cur_h);
      count = area * $urandom_range(1, 2);
      if ($urandom_range(1)) count += $urandom_range(area - 1);
      case ($urandom_range(3))
        0:       pct = 100;
        1:       pct = 50;
        default: pct = 85;
      endcase
      steady = (phase == 3);
      if (phase % 5 == 2) begin
        send_cells(count / 2, pct);
        drain();
        send_cells(count - count / 2, pct);
      end else begin
        send_cells(count, pct);
      end
      steady = 1'b0;
      random_cells += count;
      phase++;
    end

    drain();
    repeat (20) @(posedge clk);
    $display("%0d cell requests over %0d register settings, %0d records checked",
             cells_sent, settings, rec_count);
    $display("%0d frames closed on grids from 2x2 up to 9x6, partial frames up to 1024",
             frame_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== masked_grid_triangulator_core.f =====
+incdir+rtl/core
rtl/core/mgt_pkg.sv
rtl/core/mgt_ram.sv
rtl/core/masked_grid_triangulator_core.sv
rtl/core/mgt_chk.sv
bench/mgt_record_checker.sv
bench/masked_grid_triangulator_core_tb.sv
